// ----- sv/sha384_stream_hash_defines.svh -----
// assertion helper macros for the sha-384 stream hash
`ifndef SHA384_STREAM_HASH_DEFINES_SVH
`define SHA384_STREAM_HASH_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sha_pkg.sv -----
// ---------------------------------------------------------------------------
// sha_pkg
// shared types and constants of the sha-384 stream hash
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sha_pkg;

    localparam int WordBits    = 64;
    localparam int DigestWords = 6;
    localparam int QueueDepth  = 4;

    // item passed from the front part to the back part
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } t_cmd;

    typedef logic [63:0] t_word;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        round_k = k;
    endfunction

    function automatic logic [63:0] init_h(input logic [2:0] i);
        logic [63:0] h;
        case (i)
            3'd0: h = 64'hcbbb9d5dc1059ed8; 3'd1: h = 64'h629a292a367cd507;
            3'd2: h = 64'h9159015a3070dd17; 3'd3: h = 64'h152fecd8f70e5939;
            3'd4: h = 64'h67332667ffc00b31; 3'd5: h = 64'h8eb44a8768581511;
            3'd6: h = 64'hdb0c2e0d64f98fa7; 3'd7: h = 64'h47b5481dbefa4fa4;
            default: h = 64'h0;
        endcase
        init_h = h;
    endfunction

endpackage

// ----- sv/sha_if.sv -----
// ---------------------------------------------------------------------------
// sha_in_if / sha_out_if
// valid/ready channels of the sha-384 stream hash
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        end_of_message;
    modport source (output valid, data_word, valid_bytes, end_of_message, input ready);
    modport sink   (input valid, data_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_overflow;
    modport source (output valid, digest_word, word_index, last_word, length_overflow,
                    input ready);
    modport sink   (input valid, digest_word, word_index, last_word, length_overflow,
                     output ready);
endinterface

// ----- sv/sha_front.sv -----
// ---------------------------------------------------------------------------
// sha_front
// accepts input items, clamps the byte count and queues them for the core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha_in_if.sink        s_in,
    output logic          o_cmd_valid,
    output sha_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    localparam int PtrBits = $clog2(sha_pkg::QueueDepth);

    sha_pkg::t_cmd      r_mem [sha_pkg::QueueDepth];
    logic [PtrBits-1:0] r_wptr, r_rptr;
    logic [PtrBits:0]   r_count;
    logic               w_push, w_pop;
    sha_pkg::t_cmd      w_new;

    assign s_in.ready  = (r_count != sha_pkg::QueueDepth[PtrBits:0]);
    assign w_push      = s_in.valid && s_in.ready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rptr];

    // classify: clamp byte count above eight
    always_comb begin
        w_new.data   = s_in.data_word;
        w_new.nbytes = (s_in.valid_bytes > 4'd8) ? 4'd8 : s_in.valid_bytes;
        w_new.last   = s_in.end_of_message;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_new;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + {{PtrBits{1'b0}}, w_push} - {{PtrBits{1'b0}}, w_pop};
        end
    end
endmodule

// ----- sv/sha_core.sv -----
// ---------------------------------------------------------------------------
// sha_core
// byte packing, padding, 80-round compression and digest output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha_core #(
    parameter int LengthBits = 61
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sha_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    sha_out_if.source     m_out
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BYTE = 4'd1;
    localparam logic [3:0] S_PADB = 4'd2;
    localparam logic [3:0] S_PADZ = 4'd3;
    localparam logic [3:0] S_LEN  = 4'd4;
    localparam logic [3:0] S_RND  = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    localparam logic [LengthBits-1:0] MaxLen = '1;

    logic [3:0]            r_state;
    logic [63:0]           r_h [8];
    logic [63:0]           r_w [16];
    logic [63:0]           r_v [8];
    logic [6:0]            r_cnt;
    logic [LengthBits-1:0] r_len;
    logic                  r_ovf;
    logic [63:0]           r_data;
    logic [3:0]            r_left;
    logic                  r_last;
    logic                  r_pad;
    logic                  r_fin;
    logic [6:0]            r_round;
    logic [2:0]            r_oidx;

    logic [LengthBits-1:0] w_room;
    logic                  w_fits;
    logic [63:0]           w_t1, w_t2, w_sched, w_s0, w_s1;
    logic [127:0]          w_bits;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_room      = MaxLen - r_len;
    assign w_fits      = {{(LengthBits-4){1'b0}}, i_cmd.nbytes} <= w_room;
    assign w_bits      = {{(125-LengthBits){1'b0}}, r_len, 3'b000};

    // message schedule and round function on the rolling window
    always_comb begin
        w_s0    = sha_pkg::rotr(r_w[1], 1) ^ sha_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        w_s1    = sha_pkg::rotr(r_w[14], 19) ^ sha_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_sched = w_s1 + r_w[9] + w_s0 + r_w[0];
        w_t1 = r_v[7] + (sha_pkg::rotr(r_v[4], 14) ^ sha_pkg::rotr(r_v[4], 18)
               ^ sha_pkg::rotr(r_v[4], 41)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
               + sha_pkg::round_k(r_round) + r_w[0];
        w_t2 = (sha_pkg::rotr(r_v[0], 28) ^ sha_pkg::rotr(r_v[0], 34)
               ^ sha_pkg::rotr(r_v[0], 39))
               + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign m_out.valid           = (r_state == S_OUT);
    assign m_out.digest_word     = r_h[r_oidx];
    assign m_out.word_index      = r_oidx;
    assign m_out.last_word       = (r_oidx == 3'd5);
    assign m_out.length_overflow = r_ovf;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_oidx  <= '0;
            r_fin   <= 1'b0;
            r_pad   <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_data <= i_cmd.data;
                        r_last <= i_cmd.last;
                        if (w_fits) begin
                            r_len  <= r_len + {{(LengthBits-4){1'b0}}, i_cmd.nbytes};
                            r_left <= i_cmd.nbytes;
                        end else begin
                            r_ovf  <= 1'b1;
                            r_left <= 4'd0;
                        end
                        r_state <= S_BYTE;
                    end
                end
                // one data byte a cycle into the block, paused while a full block is compressed
                S_BYTE: begin
                    if (r_left != 4'd0) begin
                        r_w[r_cnt[6:3]][8*(7-r_cnt[2:0]) +: 8] <= r_data[63:56];
                        r_data <= {r_data[55:0], 8'h00};
                        r_left <= r_left - 4'd1;
                        r_cnt  <= r_cnt + 7'd1;
                        if (r_cnt == 7'd127) begin
                            r_fin   <= 1'b0;
                            r_state <= S_RND;
                        end
                    end else if (r_last) begin
                        r_state <= S_PADB;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    r_round <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                S_PADB: begin
                    r_w[r_cnt[6:3]][8*(7-r_cnt[2:0]) +: 8] <= 8'h80;
                    r_cnt   <= r_cnt + 7'd1;
                    r_state <= S_PADZ;
                    r_last  <= 1'b0;
                    r_pad   <= 1'b1;
                    if (r_cnt == 7'd127) begin
                        r_fin   <= 1'b0;
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_state <= S_RND;
                    end
                end
                // zero fill up to the length field
                S_PADZ: begin
                    if (r_cnt == 7'd112) begin
                        r_state <= S_LEN;
                    end else begin
                        r_w[r_cnt[6:3]][8*(7-r_cnt[2:0]) +: 8] <= 8'h00;
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd127) begin
                            r_fin   <= 1'b0;
                            r_round <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            r_state <= S_RND;
                        end
                    end
                end
                S_LEN: begin
                    r_w[14] <= w_bits[127:64];
                    r_w[15] <= w_bits[63:0];
                    r_cnt   <= '0;
                    r_fin   <= 1'b1;
                    r_pad   <= 1'b0;
                    r_round <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_state <= S_RND;
                end
                // one round a cycle, window shifts each round
                S_RND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_sched;
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'd79) r_state <= S_ADD;
                end
                // fold in the block, then send the digest after the final block or resume where the block filled up
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_cnt <= '0;
                    if (r_fin) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_left != 4'd0) begin
                        r_state <= S_BYTE;
                    end else if (r_last) begin
                        r_state <= S_PADB;
                    end else if (r_pad) begin
                        r_state <= S_PADZ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (m_out.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd5) begin
                            r_len   <= '0;
                            r_ovf   <= 1'b0;
                            r_cnt   <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/sha384_stream_hash.sv -----
// sha-384 stream hash: 64-bit words in, six 64-bit digest words out
// path: each word is queued, then the core packs it a byte at a time and compresses each full block
// flow: the queue holds up to four words; the core takes the next word only when idle
// finish: padding bytes, one or two compressed blocks, then six digest output items
// reset: synchronous active-low i_rst_n, loads the initial hash and empties the queue
// ---------------------------------------------------------------------------
// sha384_stream_hash
// top level: input queue front part and compression back part
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha384_stream_hash #(
    parameter int LENGTH_COUNTER_BITS = 61
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    s_in,
    sha_out_if.source m_out
);
    logic          w_cmd_valid, w_cmd_ready;
    sha_pkg::t_cmd w_cmd;

    sha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (s_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    sha_core #(.LengthBits(LENGTH_COUNTER_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .m_out       (m_out)
    );
endmodule

// ----- sv/sha_checker.sv -----
// ---------------------------------------------------------------------------
// sha_checker
// port-level checks of the digest output sequence
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha384_stream_hash_defines.svh"
module sha_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_ovalid,
    input logic       i_oready,
    input logic [2:0] i_oidx,
    input logic       i_olast
);
    `SHA_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, i_ovalid, i_oidx <= 3'd5, "index out of range")
    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, i_ovalid, i_olast == (i_oidx == 3'd5), "bad last")
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, i_ovalid && i_oready && !i_olast, i_ovalid && i_oidx == $past(i_oidx) + 3'd1, "digest items not in order")
    `SHA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_ovalid && !i_oready, i_ovalid && $stable(i_oidx), "stalled item changed")
endmodule

bind sha384_stream_hash sha_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_ovalid (m_out.valid),
    .i_oready (m_out.ready),
    .i_oidx   (m_out.word_index),
    .i_olast  (m_out.last_word)
);

// ----- verif/tb_sha384_stream_hash.sv -----
// ---------------------------------------------------------------------------
// tb_sha384_stream_hash
// self-checking bench for the sha-384 stream hash: drives message words with
// random idling, predicts each digest in software and checks every output item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sha384_stream_hash;

    // length counter narrower than the default of the block
    localparam int          LenBits   = 16;
    localparam longint      MaxLen    = (64'd1 << LenBits) - 1;
    localparam int          CycleCap  = 1500000;
    localparam int          TailItems = 20;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        eom;
        bit          hold;  // marker: wait until every digest has come back
    } msg_word_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
        logic        ovf;
    } digest_item_t;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha384_stream_hash #(.LENGTH_COUNTER_BITS(LenBits)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch)
    );

    // round constants and initial chaining value
    logic [63:0] kk [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };
    logic [63:0] iv [0:7] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    // predicted hash state
    logic [63:0] hval [0:7];
    logic [7:0]  blk_bytes [0:127];
    int          blk_fill;
    longint      msg_bytes;
    bit          msg_ovf;

    msg_word_t    word_q [$];
    digest_item_t digest_q [$];

    int  errors;
    int  cycles;
    int  n_msgs;
    int  n_digest_items;
    int  n_ovf_msgs;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // one sha-512 compression over the byte buffer
    function automatic void compress_block();
        logic [63:0] w [0:79];
        logic [63:0] v [0:7];
        logic [63:0] t1, t2, e, a;
        for (int t = 0; t < 16; t++) begin
            for (int b = 0; b < 8; b++) w[t][63 - 8*b -: 8] = blk_bytes[8*t + b];
        end
        for (int t = 16; t < 80; t++) begin
            w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
                 + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hval[i];
        for (int t = 0; t < 80; t++) begin
            e  = v[4];
            a  = v[0];
            t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
               + ((e & v[5]) ^ (~e & v[6])) + kk[t] + w[t];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hval[i] = hval[i] + v[i];
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 128) begin
            compress_block();
            blk_fill = 0;
        end
    endfunction

    function automatic void clear_hash();
        for (int i = 0; i < 8; i++) hval[i] = iv[i];
        blk_fill  = 0;
        msg_bytes = 0;
        msg_ovf   = 0;
    endfunction

    // absorb one accepted word; on end of message queue the six digest items
    function automatic void absorb_word(input msg_word_t m);
        longint       n;
        logic [127:0] bitlen;
        digest_item_t d;
        n = (m.nbytes > 8) ? 8 : m.nbytes;
        if (n > MaxLen - msg_bytes) begin
            msg_ovf = 1;
        end else begin
            msg_bytes += n;
            for (int i = 0; i < n; i++) push_byte(m.data[63 - 8*i -: 8]);
        end
        if (m.eom) begin
            bitlen = {64'd0, msg_bytes} << 3;
            push_byte(8'h80);
            while (blk_fill != 112) push_byte(8'h00);
            for (int i = 0; i < 16; i++) push_byte(bitlen[127 - 8*i -: 8]);
            for (int k = 0; k < 6; k++) begin
                d.word  = hval[k];
                d.index = k[2:0];
                d.last  = (k == 5);
                d.ovf   = msg_ovf;
                digest_q.push_back(d);
            end
            n_msgs++;
            if (msg_ovf) n_ovf_msgs++;
            clear_hash();
        end
    endfunction

    function automatic void add_word(input logic [63:0] data, input logic [3:0] nb,
                                     input logic eom);
        msg_word_t m;
        m.data   = data;
        m.nbytes = nb;
        m.eom    = eom;
        m.hold   = 0;
        word_q.push_back(m);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random message: mostly full words, sometimes short or oversized counts
    function automatic void add_random_msg(input int nwords);
        logic [3:0] nb;
        for (int i = 0; i < nwords; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    nb = 4'($urandom_range(0, 7));
                2:       nb = 4'($urandom_range(9, 15));
                default: nb = 4'd8;
            endcase
            add_word(rand64(), nb, i == nwords - 1);
        end
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // stimulus plan
    initial begin
        msg_word_t mark;
        int        total;
        i_rst_n              = 0;
        in_ch.valid          = 0;
        in_ch.data_word      = '0;
        in_ch.valid_bytes    = '0;
        in_ch.end_of_message = 0;
        out_ch.ready         = 0;
        errors = 0; n_msgs = 0; n_digest_items = 0; n_ovf_msgs = 0;
        clear_hash();

        // empty message
        add_word(rand64(), 4'd0, 1);
        // zero-byte word ahead of an all-ones word
        add_word(rand64(), 4'd0, 0);
        add_word('1, 4'd8, 1);
        // byte count above eight, all count bits set
        add_word(rand64(), 4'd15, 1);
        // garbage below the valid bytes
        add_word('1, 4'd3, 1);
        add_word(64'h0, 4'd8, 1);
        // 111 bytes: length just fits beside the padding
        for (int i = 0; i < 13; i++) add_word(rand64(), 4'd8, 0);
        add_word(rand64(), 4'd7, 1);

        // random messages, with a full drain once in the middle
        total = word_q.size();
        while (total < 140) begin
            add_random_msg($urandom_range(1, 24));
            if (total < 70 && word_q.size() >= 70) begin
                mark.hold = 1;
                mark.data = '0; mark.nbytes = '0; mark.eom = 0;
                word_q.push_back(mark);
            end
            total = word_q.size();
        end

        // short closing messages
        add_random_msg(3);
        add_random_msg(2);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // driver
    int        in_gap;
    msg_word_t cur_word;
    always @(posedge i_clk) begin
        bit        fire;
        bit        nv;
        msg_word_t m;
        if (!i_rst_n) begin
            in_ch.valid <= 0;
            in_gap = 0;
        end else begin
            fire = in_ch.valid && in_ch.ready;
            nv   = in_ch.valid && !fire;
            if (fire) absorb_word(cur_word);
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (word_q.size() != 0) begin
                    m = word_q[0];
                    if (m.hold) begin
                        if (digest_q.size() == 0) void'(word_q.pop_front());
                    end else begin
                        void'(word_q.pop_front());
                        cur_word             = m;
                        in_ch.data_word      <= m.data;
                        in_ch.valid_bytes    <= m.nbytes;
                        in_ch.end_of_message <= m.eom;
                        nv = 1;
                        if (word_q.size() > TailItems && $urandom_range(0, 5) == 0)
                            in_gap = $urandom_range(1, 10);
                    end
                end
            end
            in_ch.valid <= nv;
        end
    end

    // monitor with back-pressure bursts
    int out_stall;
    always @(posedge i_clk) begin
        digest_item_t d;
        bit           rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 0;
            out_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_digest_items++;
                if (digest_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected digest item: expected none, got %h idx %0d",
                             $time, out_ch.digest_word, out_ch.word_index);
                end else begin
                    d = digest_q.pop_front();
                    if (out_ch.digest_word !== d.word || out_ch.word_index !== d.index ||
                        out_ch.last_word !== d.last || out_ch.length_overflow !== d.ovf) begin
                        errors++;
                        $display("%0t digest mismatch: expected %h idx %0d last %b ovf %b, got %h idx %0d last %b ovf %b",
                                 $time, d.word, d.index, d.last, d.ovf, out_ch.digest_word,
                                 out_ch.word_index, out_ch.last_word, out_ch.length_overflow);
                    end
                end
            end
            rdy = 1;
            if (out_stall > 0) begin
                out_stall--;
                rdy = 0;
            end else if (word_q.size() > TailItems && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(1, 10);
                rdy = 0;
            end
            out_ch.ready <= rdy;
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleCap) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // end of run
    initial begin
        cycles = 0;
        wait (i_rst_n === 1'b1);
        while (word_q.size() != 0 || in_ch.valid || digest_q.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        errors += digest_q.size();
        $display("covered %0d messages (%0d past the length limit), %0d digest items checked",
                 n_msgs, n_ovf_msgs, n_digest_items);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
